// ===== rtl/core/twod_pkg.sv =====
// Shared types, constants and helper functions of the odometry delta block.
`timescale 1ns / 1ps
package twod_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ATAN_COUNT   = 30;
    localparam int ITER         = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;

    localparam logic [1:0] REG_MPP = 2'd0;
    localparam logic [1:0] REG_AX  = 2'd1;
    localparam logic [1:0] REG_BY  = 2'd2;
    localparam logic [1:0] REG_MID = 2'd3;

    localparam logic signed [36:0] PI_Q29      = 37'sd1686629713;
    localparam logic signed [36:0] TWO_PI_Q29  = 37'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [33:0] INV_GAIN    = 34'sd652032874;

    // One classified item between the front and the back.
    typedef struct packed {
        logic signed [31:0] dxb;
        logic signed [31:0] dyb;
        logic signed [31:0] ang;
        logic               neg;
    } t_work;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            default: v = 34'sd1 <<< (30 - i);
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/twod_front.sv =====
// Front part: scales pulses, removes offset rotation, folds the heading angle.
`timescale 1ns / 1ps
module twod_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [23:0]   i_pl,
    input  logic signed [23:0]   i_pf,
    input  logic signed [31:0]   i_hb,
    input  logic signed [31:0]   i_hc,
    input  logic [31:0]          i_mpp,
    input  logic signed [31:0]   i_ax,
    input  logic signed [31:0]   i_by,
    input  logic                 i_mid,
    input  logic                 i_q_full,
    output logic                 o_q_wr,
    output twod_pkg::t_work      o_q_data
);
    import twod_pkg::*;

    logic                r_v1, r_v2, r_v3;
    logic signed [56:0]  r_plm, r_pfm;
    logic signed [63:0]  r_hca, r_hcb;
    logic signed [34:0]  r_th;
    logic signed [31:0]  r_dxb2, r_dyb2;
    logic signed [34:0]  r_th2;
    t_work               r_out;
    logic                stall;
    logic signed [34:0]  n_th;
    logic signed [49:0]  dyb_sum, dxb_sum;
    logic signed [34:0]  n_th2;
    logic signed [35:0]  a2;
    t_work               n_out;

    assign stall    = r_v3 && i_q_full;
    assign o_ready  = !stall;
    assign o_q_wr   = r_v3 && !i_q_full;
    assign o_q_data = r_out;

    // Angle in Q5.29: twice the start heading plus one or two changes.
    always_comb begin
        n_th = ({{3{i_hb[31]}}, i_hb} <<< 1)
             + (i_mid ? {{3{i_hc[31]}}, i_hc} : ({{3{i_hc[31]}}, i_hc} <<< 1));
    end

    always_comb begin
        logic signed [36:0] cand;
        dyb_sum = 50'(((r_plm + 57'sd128) >>> 8))
                - 50'(((r_hca + 64'sd134217728) >>> 28));
        dxb_sum = 50'(((r_pfm + 57'sd128) >>> 8))
                + 50'(((r_hcb + 64'sd134217728) >>> 28));
        // Exactly one multiple of two pi lands the angle in [-pi, pi).
        n_th2 = r_th;
        for (int k = -3; k <= 3; k++) begin
            cand = 37'(r_th) - 37'(k) * TWO_PI_Q29;
            if (cand >= -PI_Q29 && cand < PI_Q29) begin
                n_th2 = cand[34:0];
            end
        end
    end

    always_comb begin
        a2         = 36'(r_th2) <<< 1;
        n_out.dxb  = r_dxb2;
        n_out.dyb  = r_dyb2;
        n_out.neg  = 1'b0;
        n_out.ang  = a2[31:0];
        if (a2 > HALF_PI_Q30) begin
            n_out.ang = 32'(a2 - PI_Q30);
            n_out.neg = 1'b1;
        end else if (a2 < -HALF_PI_Q30) begin
            n_out.ang = 32'(a2 + PI_Q30);
            n_out.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (!stall) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_plm  <= 57'(i_pl * $signed({1'b0, i_mpp}));
            r_pfm  <= 57'(i_pf * $signed({1'b0, i_mpp}));
            r_hca  <= i_hc * i_ax;
            r_hcb  <= i_hc * i_by;
            r_th   <= n_th;
            r_dyb2 <= sat32(68'(dyb_sum));
            r_dxb2 <= sat32(68'(dxb_sum));
            r_th2  <= n_th2;
            r_out  <= n_out;
        end
    end

endmodule

// ===== rtl/core/twod_queue.sv =====
// Short queue that decouples the front and the back.
`timescale 1ns / 1ps
module twod_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  twod_pkg::t_work  i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output twod_pkg::t_work  o_data
);
    import twod_pkg::*;

    t_work       r_mem [4];
    logic [1:0]  r_wp, r_rp;
    logic [2:0]  r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, i_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/twod_back.sv =====
// Back part: pipelined CORDIC, rotation into the world frame, output register.
`timescale 1ns / 1ps
module twod_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  twod_pkg::t_work     i_q_data,
    output logic                o_q_rd,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [127:0]        o_data
);
    import twod_pkg::*;

    logic               r_v  [ITER+1];
    logic signed [33:0] r_x  [ITER+1];
    logic signed [33:0] r_y  [ITER+1];
    logic signed [33:0] r_z  [ITER+1];
    logic signed [31:0] r_dx [ITER+1];
    logic signed [31:0] r_dy [ITER+1];
    logic               r_ng [ITER+1];
    logic               r_vc, r_vp, r_vo;
    logic signed [33:0] r_c, r_s;
    logic signed [31:0] r_dxc, r_dyc, r_dxp, r_dyp;
    logic signed [65:0] r_p_xc, r_p_ys, r_p_xs, r_p_yc;
    logic [127:0]       r_o;
    logic               adv;
    logic signed [66:0] wx, wy;

    assign adv     = !(r_vo && !i_ready);
    assign o_q_rd  = adv && !i_q_empty;
    assign o_valid = r_vo;
    assign o_data  = r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x[0]  <= INV_GAIN;
            r_y[0]  <= '0;
            r_z[0]  <= 34'(i_q_data.ang);
            r_dx[0] <= i_q_data.dxb;
            r_dy[0] <= i_q_data.dyb;
            r_ng[0] <= i_q_data.neg;
        end
    end

    for (genvar k = 0; k < ITER; k++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_v[k+1] <= r_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_q30(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_q30(k);
                end
                r_dx[k+1] <= r_dx[k];
                r_dy[k+1] <= r_dy[k];
                r_ng[k+1] <= r_ng[k];
            end
        end
    end

    // Round to nearest with ties upward, then clamp.
    always_comb begin
        wx = 67'(r_p_xc) - 67'(r_p_ys) + 67'sd536870912;
        wy = 67'(r_p_xs) + 67'(r_p_yc) + 67'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
            r_vp <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_vc <= r_v[ITER];
            r_vp <= r_vc;
            r_vo <= r_vp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c    <= r_ng[ITER] ? -r_x[ITER] : r_x[ITER];
            r_s    <= r_ng[ITER] ? -r_y[ITER] : r_y[ITER];
            r_dxc  <= r_dx[ITER];
            r_dyc  <= r_dy[ITER];
            r_p_xc <= r_dxc * r_c;
            r_p_ys <= r_dyc * r_s;
            r_p_xs <= r_dxc * r_s;
            r_p_yc <= r_dyc * r_c;
            r_dxp  <= r_dxc;
            r_dyp  <= r_dyc;
            r_o    <= {sat32(68'(wy >>> 30)), sat32(68'(wx >>> 30)), r_dyp, r_dxp};
        end
    end

endmodule

// ===== rtl/core/two_wheel_odometry_delta.sv =====
// Path: the front registers, the queue, CORDIC_STEPS stages and 3 more registers.
// Throughput: one item per cycle unless stalled, set by the fully pipelined CORDIC and the rotator.
// The front stalls only when the four-entry queue is full; the back only when m_axis_tready is low.
// Synchronous active-low reset empties pipeline and queue and loads the register
// reset values: 429497 metres per pulse, zero offsets, midpoint mode on.
`timescale 1ns / 1ps
module two_wheel_odometry_delta (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // pulses_lateral[23:0], pulses_forward[47:24], heading_before[79:48], heading_change[111:80]
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // body_dx[31:0], body_dy[63:32], world_dx[95:64], world_dy[127:96]
    output logic [127:0]  m_axis_tdata,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import twod_pkg::*;

    logic [31:0]         r_mpp;
    logic signed [31:0]  r_ax, r_by;
    logic                r_mid;
    logic                q_wr, q_rd, q_full, q_empty;
    t_work               q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpp <= 32'd429497;
            r_ax  <= '0;
            r_by  <= '0;
            r_mid <= 1'b1;
        end else if (i_cfg_valid && i_cfg_index[7:2] == 6'd0) begin
            case (i_cfg_index[1:0])
                REG_MPP: r_mpp <= i_cfg_data;
                REG_AX:  r_ax  <= i_cfg_data;
                REG_BY:  r_by  <= i_cfg_data;
                REG_MID: r_mid <= i_cfg_data[0];
                default: r_mid <= r_mid;
            endcase
        end
    end

    twod_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_pl     (s_axis_tdata[23:0]),
        .i_pf     (s_axis_tdata[47:24]),
        .i_hb     (s_axis_tdata[79:48]),
        .i_hc     (s_axis_tdata[111:80]),
        .i_mpp    (r_mpp),
        .i_ax     (r_ax),
        .i_by     (r_by),
        .i_mid    (r_mid),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_data (q_in)
    );

    twod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    twod_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_out),
        .o_q_rd    (q_rd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

// ===== bench/tb_two_wheel_odometry_delta.sv =====
// Self-checking testbench of the two-wheel odometry delta block with a scoreboard class.
`timescale 1ns / 1ps
module tb_two_wheel_odometry_delta;
    import twod_pkg::*;

    typedef struct packed {
        logic signed [31:0] heading_change;
        logic signed [31:0] heading_before;
        logic signed [23:0] pulses_forward;
        logic signed [23:0] pulses_lateral;
    } t_window;

    typedef struct packed {
        logic signed [31:0] world_dy;
        logic signed [31:0] world_dx;
        logic signed [31:0] body_dy;
        logic signed [31:0] body_dx;
    } t_step;

    class odometry_scoreboard;
        localparam longint PI29     = 64'sd1686629713;
        localparam longint TWO_PI29 = 64'sd3373259426;
        localparam longint HALF_PI30 = 64'sd1686629713;
        localparam longint PI30     = 64'sd3373259426;
        localparam longint UNIT_GAIN = 64'sd652032874;

        longint arctan [30];
        logic [31:0] scale;
        longint      lat_offset;
        longint      fwd_offset;
        bit          midpoint;
        t_step       pending [$];
        int          mismatches;

        function void init();
            longint fixed_head [10] = '{843314857, 497837829, 263043837, 133525159,
                                        67021687, 33543516, 16775851, 8388437,
                                        4194283, 2097149};
            for (int i = 0; i < 30; i++) begin
                arctan[i] = (i < 10) ? fixed_head[i] : (longint'(1) << (30 - i));
            end
            scale = 32'd429497;
            lat_offset = 0;
            fwd_offset = 0;
            midpoint = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [31:0] value);
            if (idx[7:2] == 6'd0) begin
                case (idx[1:0])
                    REG_MPP: scale = value;
                    REG_AX:  lat_offset = longint'(signed'(value));
                    REG_BY:  fwd_offset = longint'(signed'(value));
                    REG_MID: midpoint = value[0];
                    default: ;
                endcase
            end
        endfunction

        // Round to nearest with ties toward +infinity; >>> on longint floors.
        function longint round_down(longint x, int n);
            return (x + (longint'(1) << (n - 1))) >>> n;
        endfunction

        function longint clamp(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function void note_window(t_window w);
            longint pl, pf, hb, hc, dx, dy, th, ang, c, s, xs, ys;
            bit flip;
            t_step r;
            pl = longint'(w.pulses_lateral);
            pf = longint'(w.pulses_forward);
            hb = longint'(w.heading_before);
            hc = longint'(w.heading_change);
            dy = round_down(pl * longint'({32'd0, scale}), 8) - round_down(hc * lat_offset, 28);
            dx = round_down(pf * longint'({32'd0, scale}), 8) + round_down(hc * fwd_offset, 28);
            dx = clamp(dx);
            dy = clamp(dy);
            th = 2 * hb + (midpoint ? hc : 2 * hc);
            th = th % TWO_PI29;
            if (th < 0) th += TWO_PI29;
            if (th >= PI29) th -= TWO_PI29;
            ang = th * 2;
            flip = 1'b0;
            if (ang > HALF_PI30) begin
                ang -= PI30;
                flip = 1'b1;
            end else if (ang < -HALF_PI30) begin
                ang += PI30;
                flip = 1'b1;
            end
            c = UNIT_GAIN;
            s = 0;
            for (int i = 0; i < ITER; i++) begin
                xs = c >>> i;
                ys = s >>> i;
                if (ang >= 0) begin
                    c -= ys;
                    s += xs;
                    ang -= arctan[i];
                end else begin
                    c += ys;
                    s -= xs;
                    ang += arctan[i];
                end
            end
            if (flip) begin
                c = -c;
                s = -s;
            end
            r.body_dx = dx[31:0];
            r.body_dy = dy[31:0];
            r.world_dx = 32'(clamp(round_down(dx * c - dy * s, 30)));
            r.world_dy = 32'(clamp(round_down(dx * s + dy * c, 30)));
            pending.push_back(r);
        endfunction

        function void check_step(t_step got);
            t_step want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("step mismatch: body_dx %0d/%0d body_dy %0d/%0d",
                             want.body_dx, got.body_dx, want.body_dy, got.body_dy);
                    $display("  world_dx %0d/%0d world_dy %0d/%0d (expected/actual)",
                             want.world_dx, got.world_dx, want.world_dy, got.world_dy);
                end
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    odometry_scoreboard steps = new();
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;

    two_wheel_odometry_delta u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) steps.check_step(m_axis_tdata);
    end

    task automatic send_window(t_window w);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        steps.note_window(w);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] value);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        steps.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (steps.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_window random_window();
        t_window w;
        w = 112'({$urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(3))
            0: ;
            1: begin
                w.pulses_lateral = 24'($signed($urandom_range(8191)) - 4096);
                w.pulses_forward = 24'($signed($urandom_range(8191)) - 4096);
            end
            2: begin
                w.heading_change = $signed($urandom_range(2097151)) - 1048576;
            end
            default: begin
                w.pulses_lateral = 24'($signed($urandom_range(255)) - 128);
                w.pulses_forward = 24'($signed($urandom_range(255)) - 128);
                w.heading_change = $signed($urandom_range(65535)) - 32768;
            end
        endcase
        return w;
    endfunction

    initial begin
        #2_000_000;
        $display("FAIL two_wheel_odometry_delta");
        $finish;
    end

    initial begin
        t_window w;
        logic signed [31:0] headings [8] = '{0, 32'sh7FFFFFFF, 32'sh80000000,
                                            843314857, -843314857, 421657428,
                                            -421657428, 843314856};
        steps.init();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset values first; an out-of-range index must be ignored.
        write_reg(8'd4, $urandom);
        write_reg(8'd255, $urandom);
        foreach (headings[i]) begin
            w.pulses_lateral = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
            w.pulses_forward = (i % 3) ? 24'sh800000 : 24'sh7FFFFF;
            w.heading_before = headings[i];
            w.heading_change = headings[7 - i];
            send_window(w);
        end
        send_window('0);
        w = '0;
        w.pulses_forward = 24'sd1;
        w.pulses_lateral = -24'sd1;
        w.heading_change = 32'sh7FFFFFFF;
        send_window(w);
        w.heading_change = 32'sh80000000;
        send_window(w);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg({6'd0, REG_MPP}, 32'd0);
                    write_reg({6'd0, REG_AX}, 32'h7FFFFFFF);
                    write_reg({6'd0, REG_BY}, 32'h80000000);
                    write_reg({6'd0, REG_MID}, 32'd0);
                end
                2: begin
                    write_reg({6'd0, REG_MPP}, 32'hFFFFFFFF);
                    write_reg({6'd0, REG_AX}, 32'h80000000);
                    write_reg({6'd0, REG_BY}, 32'h7FFFFFFF);
                    write_reg({6'd0, REG_MID}, 32'hFFFFFFFF);
                end
                4: begin
                    write_reg({6'd0, REG_MPP}, 32'd429497);
                    write_reg({6'd0, REG_AX}, $signed($urandom_range(33554431)) - 16777216);
                    write_reg({6'd0, REG_BY}, $signed($urandom_range(33554431)) - 16777216);
                    write_reg({6'd0, REG_MID}, 32'd1);
                end
                default: begin
                    write_reg({6'd0, REG_MPP}, $urandom);
                    write_reg({6'd0, REG_AX}, $urandom);
                    write_reg({6'd0, REG_BY}, $urandom);
                    write_reg({6'd0, REG_MID}, $urandom);
                end
            endcase
            sender_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 66 : 0;
            receiver_idle_pct = (phase < 2) ? 66 : (phase < 4) ? 25 : 0;
            repeat (125) send_window(random_window());
            drain();
        end

        if (steps.mismatches == 0 && steps.pending.size() == 0) begin
            $display("PASS two_wheel_odometry_delta");
        end else begin
            $display("FAIL two_wheel_odometry_delta");
        end
        $finish;
    end
endmodule
